// ===== rtl/core/hrls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrls_pkg
// Shared types, codes, the microcode table and character helpers of the
// hex record loader sender.
// ----------------------------------------------------------------------------
package hrls_pkg;

  // item operation codes
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_JUMP  = 2'd2;
  localparam logic [1:0] OP_REPLY = 2'd3;

  // status codes
  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_OK    = 3'd1;
  localparam logic [2:0] ST_RETRY = 3'd2;
  localparam logic [2:0] ST_FAIL  = 3'd3;
  localparam logic [2:0] ST_UNEXP = 3'd4;

  // link characters
  localparam logic [7:0] CHAR_W = 8'h57;
  localparam logic [7:0] CHAR_J = 8'h4a;
  localparam logic [7:0] CHAR_O = 8'h4f;

  localparam logic [3:0] MAX_TRIES_RST = 4'd10;

  // microcode entry points
  localparam logic [3:0] PC_REC  = 4'd0;
  localparam logic [3:0] PC_JMP  = 4'd6;
  localparam logic [3:0] PC_STAT = 4'd10;

  // character source of one step
  typedef enum logic [2:0] {
    SRC_NONE  = 3'd0,
    SRC_W     = 3'd1,
    SRC_J     = 3'd2,
    SRC_ADDR  = 3'd3,
    SRC_LEN   = 3'd4,
    SRC_BUF   = 3'd5,
    SRC_CSUM  = 3'd6,
    SRC_STACK = 3'd7
  } hrls_src_t;

  // sequencing condition applied when a step has finished its digits
  typedef enum logic [1:0] {
    C_NEXT = 2'd0,
    C_ZCNT = 2'd1,
    C_MORE = 2'd2,
    C_END  = 2'd3
  } hrls_cond_t;

  typedef struct packed {
    logic       emit;
    hrls_src_t  src;
    logic [2:0] ndig;
    logic       last;
    hrls_cond_t cond;
    logic [3:0] tgt;
  } hrls_uword_t;

  // program start request from the decoder
  typedef struct packed {
    logic       go;
    logic [3:0] pc;
  } hrls_start_t;

  // per-cycle datapath control from the sequencer
  typedef struct packed {
    logic       fire;
    hrls_src_t  src;
    logic [2:0] dig;
    logic       last;
  } hrls_ctl_t;

  function automatic hrls_uword_t ucode(input logic [3:0] pc);
    hrls_uword_t uw;
    uw = '{emit: 1'b0, src: SRC_NONE, ndig: 3'd0, last: 1'b0, cond: C_END, tgt: 4'd0};
    unique case (pc)
      // write record
      4'd0:  uw = '{1'b1, SRC_W,     3'd0, 1'b0, C_NEXT, 4'd0};
      4'd1:  uw = '{1'b1, SRC_ADDR,  3'd7, 1'b0, C_NEXT, 4'd0};
      4'd2:  uw = '{1'b1, SRC_LEN,   3'd3, 1'b0, C_NEXT, 4'd0};
      4'd3:  uw = '{1'b0, SRC_NONE,  3'd0, 1'b0, C_ZCNT, 4'd5};
      4'd4:  uw = '{1'b1, SRC_BUF,   3'd1, 1'b0, C_MORE, 4'd0};
      4'd5:  uw = '{1'b1, SRC_CSUM,  3'd1, 1'b1, C_END,  4'd0};
      // jump command
      4'd6:  uw = '{1'b1, SRC_J,     3'd0, 1'b0, C_NEXT, 4'd0};
      4'd7:  uw = '{1'b1, SRC_ADDR,  3'd7, 1'b0, C_NEXT, 4'd0};
      4'd8:  uw = '{1'b1, SRC_STACK, 3'd7, 1'b0, C_NEXT, 4'd0};
      4'd9:  uw = '{1'b1, SRC_CSUM,  3'd1, 1'b1, C_END,  4'd0};
      // status only
      4'd10: uw = '{1'b1, SRC_NONE,  3'd0, 1'b1, C_END,  4'd0};
      default: uw = '{1'b0, SRC_NONE, 3'd0, 1'b0, C_END, 4'd0};
    endcase
    return uw;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    c = 8'h30;
    unique case (nib)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'ha: c = 8'h61;
      4'hb: c = 8'h62;
      4'hc: c = 8'h63;
      4'hd: c = 8'h64;
      4'he: c = 8'h65;
      4'hf: c = 8'h66;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] xor_bytes(input logic [31:0] v);
    return v[31:24] ^ v[23:16] ^ v[15:8] ^ v[7:0];
  endfunction

endpackage

// ===== rtl/core/hrls_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrls_sequencer
// Step counter, digit counter and byte counter walking the microcode table.
// ----------------------------------------------------------------------------
module hrls_sequencer #(
  parameter int BI_W = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hrls_pkg::hrls_start_t start,
  input  logic [4:0]           cnt,
  input  logic                 out_free,
  output logic                 busy,
  output logic [BI_W-1:0]      bi,
  output hrls_pkg::hrls_ctl_t  ctl
);

  logic              busy_r, busy_nxt;
  logic [3:0]        pc_r, pc_nxt;
  logic [2:0]        dig_r, dig_nxt;
  logic [BI_W-1:0]   bi_r, bi_nxt;
  hrls_pkg::hrls_uword_t uw, uw_n;
  logic              step_go;
  logic              more;
  logic [3:0]        npc;

  assign uw      = hrls_pkg::ucode(pc_r);
  assign step_go = busy_r && (!uw.emit || out_free);
  assign more    = (5'(bi_r) + 5'd1) < cnt;

  always_comb begin
    npc = pc_r + 4'd1;
    priority if (uw.cond == hrls_pkg::C_ZCNT && cnt == 5'd0) begin
      npc = uw.tgt;
    end else if (uw.cond == hrls_pkg::C_MORE && more) begin
      npc = pc_r;
    end
  end

  assign uw_n = hrls_pkg::ucode(start.go ? start.pc : npc);

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    dig_nxt  = dig_r;
    bi_nxt   = bi_r;
    if (start.go) begin
      busy_nxt = 1'b1;
      pc_nxt   = start.pc;
      dig_nxt  = uw_n.ndig;
    end else if (step_go) begin
      if (uw.emit && dig_r != 3'd0) begin
        dig_nxt = dig_r - 3'd1;
      end else begin
        unique case (uw.cond)
          hrls_pkg::C_END: begin
            busy_nxt = 1'b0;
          end
          hrls_pkg::C_ZCNT: begin
            bi_nxt  = '0;
            pc_nxt  = npc;
            dig_nxt = uw_n.ndig;
          end
          hrls_pkg::C_MORE: begin
            if (more) begin
              bi_nxt = bi_r + BI_W'(1);
            end
            pc_nxt  = npc;
            dig_nxt = uw_n.ndig;
          end
          hrls_pkg::C_NEXT: begin
            pc_nxt  = npc;
            dig_nxt = uw_n.ndig;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= 4'd0;
      dig_r  <= 3'd0;
      bi_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      dig_r  <= dig_nxt;
      bi_r   <= bi_nxt;
    end
  end

  assign busy     = busy_r;
  assign bi       = bi_r;
  assign ctl.fire = step_go && uw.emit;
  assign ctl.src  = uw.src;
  assign ctl.dig  = dig_r;
  assign ctl.last = uw.last && dig_r == 3'd0;

endmodule

// ===== rtl/core/hex_record_loader_sender_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_loader_sender_unit
// Sender side of a serial loader link: formats write records and jump
// commands as lowercase hex text, tracks replies and retransmits records.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | contents
//  in_*     | input     | in_valid/in_stall | op, address, length, data, stack, reply
//  out_*    | output    | out_valid/out_stall | has_char, link_char, status, last
//  cfg_*    | input     | cfg_valid/cfg_ready | max_tries
//
//  an item is decoded in the cycle it is accepted; its results then come
//  from a microcoded sequencer, one per cycle while the output is free
//  (a write record of n bytes gives 15 + 2n results plus one step without a result)
//  in_stall is high while the sequencer runs a program
//  a stalled output holds the sequencer on its current step
//  reset (synchronous, rst_n low) returns to idle with max_tries of ten
// ----------------------------------------------------------------------------
module hex_record_loader_sender_unit #(
  parameter int MAX_RECORD = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_address,
  input  logic [4:0]  in_record_length,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_stack_value,
  input  logic [7:0]  in_reply_byte,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_has_char,
  output logic [7:0]  out_link_char,
  output logic [2:0]  out_status,
  output logic        out_last,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_max_tries
);

  localparam int BI_W = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;
  localparam logic [4:0] MAX_LEN = 5'(MAX_RECORD);

  // one-hot exchange phase
  typedef enum logic [3:0] {
    PH_IDLE       = 4'b0001,
    PH_COLLECT    = 4'b0010,
    PH_WAIT_WRITE = 4'b0100,
    PH_WAIT_JUMP  = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  max_tries_r;
  logic [3:0]  tries_r, tries_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [4:0]  rcv_r, rcv_nxt;
  logic [31:0] addr_r;
  logic [31:0] stk_r;
  logic [7:0]  cks_r, cks_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [7:0]  buf_r [MAX_RECORD];

  logic        in_acc;
  logic        busy;
  logic [BI_W-1:0] bi;
  hrls_pkg::hrls_start_t start;
  hrls_pkg::hrls_ctl_t   ctl;

  logic [4:0]  len_sat;
  logic [4:0]  rcv_inc;
  logic        load_addr;
  logic        buf_we;

  // output register
  logic        ov_r;
  logic        has_r;
  logic [7:0]  char_r;
  logic [2:0]  ost_r;
  logic        last_r;
  logic        out_free;
  logic [31:0] word;
  logic [3:0]  nib;
  logic [7:0]  char_sel;

  assign in_stall  = busy;
  assign in_acc    = in_valid && !busy;
  assign cfg_ready = 1'b1;

  assign len_sat = (in_record_length > MAX_LEN) ? MAX_LEN : in_record_length;
  assign rcv_inc = rcv_r + 5'd1;

  // item decode: updates exchange state and picks the program to run
  always_comb begin
    phase_nxt = phase_r;
    tries_nxt = tries_r;
    cnt_nxt   = cnt_r;
    rcv_nxt   = rcv_r;
    cks_nxt   = cks_r;
    st_nxt    = st_r;
    load_addr = 1'b0;
    buf_we    = 1'b0;
    start     = '{go: 1'b0, pc: hrls_pkg::PC_STAT};
    if (in_acc) begin
      priority if (in_op == hrls_pkg::OP_BEGIN && phase_r == PH_IDLE) begin
        load_addr = 1'b1;
        cnt_nxt   = len_sat;
        rcv_nxt   = 5'd0;
        cks_nxt   = hrls_pkg::xor_bytes(in_address);
        if (len_sat == 5'd0) begin
          // empty record goes out at once
          tries_nxt = 4'd1;
          st_nxt    = hrls_pkg::ST_NONE;
          start     = '{go: 1'b1, pc: hrls_pkg::PC_REC};
          phase_nxt = PH_WAIT_WRITE;
        end else begin
          tries_nxt = 4'd0;
          phase_nxt = PH_COLLECT;
        end
      end else if (in_op == hrls_pkg::OP_DATA && phase_r == PH_COLLECT) begin
        buf_we  = rcv_r < MAX_LEN;
        cks_nxt = cks_r ^ in_data_byte;
        rcv_nxt = rcv_inc;
        if (rcv_inc >= cnt_r) begin
          tries_nxt = tries_r + 4'd1;
          st_nxt    = hrls_pkg::ST_NONE;
          start     = '{go: 1'b1, pc: hrls_pkg::PC_REC};
          phase_nxt = PH_WAIT_WRITE;
        end
      end else if (in_op == hrls_pkg::OP_JUMP && phase_r == PH_IDLE) begin
        load_addr = 1'b1;
        cks_nxt   = hrls_pkg::xor_bytes(in_address) ^ hrls_pkg::xor_bytes(in_stack_value);
        st_nxt    = hrls_pkg::ST_NONE;
        start     = '{go: 1'b1, pc: hrls_pkg::PC_JMP};
        phase_nxt = PH_WAIT_JUMP;
      end else if (in_op == hrls_pkg::OP_REPLY && phase_r == PH_WAIT_WRITE) begin
        if (in_reply_byte == hrls_pkg::CHAR_O) begin
          st_nxt    = hrls_pkg::ST_OK;
          start     = '{go: 1'b1, pc: hrls_pkg::PC_STAT};
          phase_nxt = PH_IDLE;
        end else if (tries_r < max_tries_r) begin
          // resend the buffered record
          tries_nxt = tries_r + 4'd1;
          st_nxt    = hrls_pkg::ST_RETRY;
          start     = '{go: 1'b1, pc: hrls_pkg::PC_REC};
        end else begin
          st_nxt    = hrls_pkg::ST_FAIL;
          start     = '{go: 1'b1, pc: hrls_pkg::PC_STAT};
          phase_nxt = PH_IDLE;
        end
      end else if (in_op == hrls_pkg::OP_REPLY && phase_r == PH_WAIT_JUMP) begin
        st_nxt    = (in_reply_byte == hrls_pkg::CHAR_O) ? hrls_pkg::ST_OK : hrls_pkg::ST_FAIL;
        start     = '{go: 1'b1, pc: hrls_pkg::PC_STAT};
        phase_nxt = PH_IDLE;
      end else begin
        // item not expected in this phase: report and leave state alone
        st_nxt = hrls_pkg::ST_UNEXP;
        start  = '{go: 1'b1, pc: hrls_pkg::PC_STAT};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      max_tries_r <= hrls_pkg::MAX_TRIES_RST;
      tries_r     <= 4'd0;
      cnt_r       <= 5'd0;
      rcv_r       <= 5'd0;
      cks_r       <= 8'd0;
      st_r        <= hrls_pkg::ST_NONE;
    end else begin
      phase_r <= phase_nxt;
      tries_r <= tries_nxt;
      cnt_r   <= cnt_nxt;
      rcv_r   <= rcv_nxt;
      cks_r   <= cks_nxt;
      st_r    <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        max_tries_r <= cfg_max_tries;
      end
    end
  end

  // payload registers and record buffer
  always_ff @(posedge clk) begin
    if (load_addr) begin
      addr_r <= in_address;
      stk_r  <= in_stack_value;
    end
    if (buf_we) begin
      buf_r[rcv_r[BI_W-1:0]] <= in_data_byte;
    end
  end

  hrls_sequencer #(
    .BI_W (BI_W)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cnt      (cnt_r),
    .out_free (out_free),
    .busy     (busy),
    .bi       (bi),
    .ctl      (ctl)
  );

  // character datapath: pick a word, then one nibble of it
  always_comb begin
    unique case (ctl.src)
      hrls_pkg::SRC_ADDR:  word = addr_r;
      hrls_pkg::SRC_STACK: word = stk_r;
      hrls_pkg::SRC_LEN:   word = {27'd0, cnt_r};
      hrls_pkg::SRC_BUF:   word = {24'd0, buf_r[bi]};
      hrls_pkg::SRC_CSUM:  word = {24'd0, cks_r};
      hrls_pkg::SRC_NONE,
      hrls_pkg::SRC_W,
      hrls_pkg::SRC_J:     word = 32'd0;
    endcase
  end

  assign nib = word[{ctl.dig, 2'b00} +: 4];

  always_comb begin
    unique case (ctl.src)
      hrls_pkg::SRC_NONE: char_sel = 8'd0;
      hrls_pkg::SRC_W:    char_sel = hrls_pkg::CHAR_W;
      hrls_pkg::SRC_J:    char_sel = hrls_pkg::CHAR_J;
      hrls_pkg::SRC_ADDR,
      hrls_pkg::SRC_LEN,
      hrls_pkg::SRC_BUF,
      hrls_pkg::SRC_CSUM,
      hrls_pkg::SRC_STACK: char_sel = hrls_pkg::hex_char(nib);
    endcase
  end

  assign out_free = !ov_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ctl.fire) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      has_r  <= ctl.src != hrls_pkg::SRC_NONE;
      char_r <= char_sel;
      ost_r  <= st_r;
      last_r <= ctl.last;
    end
  end

  assign out_valid     = ov_r;
  assign out_has_char  = has_r;
  assign out_link_char = char_r;
  assign out_status    = ost_r;
  assign out_last      = last_r;

endmodule

// ===== sim/hex_record_loader_sender_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_loader_sender_unit_test
// Self-checking bench for the loader link sender: a table of opening items,
// then random record, jump and noise exchanges under five retry limits, every
// result checked in order against a built-in model of the text formatter.
// ----------------------------------------------------------------------------
module hex_record_loader_sender_unit_test;

  // codes shared with the block
  localparam logic [1:0] OP_BEGIN      = hrls_pkg::OP_BEGIN;
  localparam logic [1:0] OP_DATA       = hrls_pkg::OP_DATA;
  localparam logic [1:0] OP_JUMP       = hrls_pkg::OP_JUMP;
  localparam logic [1:0] OP_REPLY      = hrls_pkg::OP_REPLY;
  localparam logic [2:0] ST_NONE       = hrls_pkg::ST_NONE;
  localparam logic [2:0] ST_OK         = hrls_pkg::ST_OK;
  localparam logic [2:0] ST_RETRY      = hrls_pkg::ST_RETRY;
  localparam logic [2:0] ST_FAIL       = hrls_pkg::ST_FAIL;
  localparam logic [2:0] ST_UNEXP      = hrls_pkg::ST_UNEXP;
  localparam logic [7:0] CHAR_W        = hrls_pkg::CHAR_W;
  localparam logic [7:0] CHAR_J        = hrls_pkg::CHAR_J;
  localparam logic [7:0] CHAR_O        = hrls_pkg::CHAR_O;
  localparam logic [3:0] MAX_TRIES_RST = hrls_pkg::MAX_TRIES_RST;

  localparam int RECORD_MAX = 16;
  localparam int SETTLE_CYCLES = 8;        // idle cycles before a register write
  localparam int DRAIN_LIMIT = 200000;     // cycles allowed for the last results
  localparam int PHASE_ITEMS = 65;         // random items per retry-limit setting
  localparam int PRESSURE_AFTER = 150;     // results seen before the long hold-off
  localparam int PRESSURE_CYCLES = 250;
  localparam int MISMATCH_PRINTS = 40;
  // worst case: ~400 items x 47 results, each behind the longest receiver stall,
  // plus sender gaps, at 4 ns, taken four times over
  localparam int RUN_LIMIT_NS = 25000000;

  // phases of the link as seen from the sender
  typedef enum logic [3:0] {
    LINK_IDLE       = 4'b0001,
    LINK_COLLECT    = 4'b0010,
    LINK_WAIT_WRITE = 4'b0100,
    LINK_WAIT_JUMP  = 4'b1000
  } link_phase_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] address;
    logic [4:0]  record_length;
    logic [7:0]  data_byte;
    logic [31:0] stack_value;
    logic [7:0]  reply_byte;
  } loader_item_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] link_char;
    logic [2:0] status;
    logic       last;
  } link_result_t;

  // one opening row; typed rows carry their single status-only result
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] address;
    logic [4:0]  record_length;
    logic [7:0]  data_byte;
    logic [31:0] stack_value;
    logic [7:0]  reply_byte;
    logic [4:0]  copies;
    logic        typed;
    logic [2:0]  typed_status;
  } opening_row_t;

  localparam int OPENING_ROWS = 14;
  localparam opening_row_t OPENING [OPENING_ROWS] = '{
    // reply with nothing outstanding
    '{OP_REPLY, 32'h0000_0000, 5'd0,  8'h00, 32'h0000_0000, CHAR_O, 5'd1,  1'b1, ST_UNEXP},
    // zero length record goes out on the begin item
    '{OP_BEGIN, 32'h0000_0000, 5'd0,  8'h00, 32'h0000_0000, 8'h00,  5'd1,  1'b0, ST_NONE},
    // lowercase o is not an ack: retransmit
    '{OP_REPLY, 32'h0000_0000, 5'd0,  8'h00, 32'h0000_0000, 8'h6f,  5'd1,  1'b0, ST_NONE},
    '{OP_REPLY, 32'h0000_0000, 5'd0,  8'h00, 32'h0000_0000, CHAR_O, 5'd1,  1'b1, ST_OK},
    // jump with extreme address and stack
    '{OP_JUMP,  32'hffff_ffff, 5'd31, 8'hff, 32'h0000_0000, 8'hff,  5'd1,  1'b0, ST_NONE},
    // jump refused fails at once
    '{OP_REPLY, 32'h0000_0000, 5'd0,  8'h00, 32'h0000_0000, 8'h00,  5'd1,  1'b1, ST_FAIL},
    '{OP_JUMP,  32'h0000_0000, 5'd0,  8'h00, 32'hffff_ffff, 8'h00,  5'd1,  1'b0, ST_NONE},
    '{OP_REPLY, 32'h0000_0000, 5'd0,  8'h00, 32'h0000_0000, CHAR_O, 5'd1,  1'b1, ST_OK},
    // oversize length saturates to a full record
    '{OP_BEGIN, 32'hffff_ffff, 5'd31, 8'h00, 32'h0000_0000, 8'h00,  5'd1,  1'b0, ST_NONE},
    // begin and jump while bytes are still owed
    '{OP_BEGIN, 32'h1234_5678, 5'd2,  8'h00, 32'h0000_0000, 8'h00,  5'd1,  1'b1, ST_UNEXP},
    '{OP_JUMP,  32'h0000_0000, 5'd0,  8'h00, 32'h0000_0000, 8'h00,  5'd1,  1'b1, ST_UNEXP},
    '{OP_DATA,  32'h0000_0000, 5'd0,  8'h00, 32'h0000_0000, 8'h00,  5'd1,  1'b0, ST_NONE},
    '{OP_DATA,  32'h0000_0000, 5'd0,  8'hff, 32'h0000_0000, 8'h00,  5'd15, 1'b0, ST_NONE},
    '{OP_REPLY, 32'h0000_0000, 5'd0,  8'h00, 32'h0000_0000, CHAR_O, 5'd1,  1'b1, ST_OK}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [31:0] in_address;
  logic [4:0]  in_record_length;
  logic [7:0]  in_data_byte;
  logic [31:0] in_stack_value;
  logic [7:0]  in_reply_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_has_char;
  logic [7:0]  out_link_char;
  logic [2:0]  out_status;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_max_tries;

  // model of the sender: link phase, record being built, retry count
  link_phase_t link_phase;
  logic [31:0] rec_address;
  logic [4:0]  rec_count;
  logic [4:0]  rec_got;
  logic [7:0]  rec_csum;
  logic [3:0]  rec_tries;
  logic [3:0]  tries_limit;
  logic [7:0]  rec_bytes [RECORD_MAX];

  link_result_t item_results[$];        // results of the item just taken
  link_result_t link_results_due[$];    // results still to come, oldest first

  int unsigned items_taken;
  int unsigned results_checked;
  int unsigned mismatches;
  bit          sender_steady;

  hex_record_loader_sender_unit #(
    .MAX_RECORD(RECORD_MAX)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_address       (in_address),
    .in_record_length (in_record_length),
    .in_data_byte     (in_data_byte),
    .in_stack_value   (in_stack_value),
    .in_reply_byte    (in_reply_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_has_char     (out_has_char),
    .out_link_char    (out_link_char),
    .out_status       (out_status),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_tries    (cfg_max_tries)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MISMATCH_PRINTS) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------- model

  function automatic logic [7:0] fold_bytes(input logic [31:0] v);
    logic [7:0] acc;
    int i;
    acc = 8'h00;
    for (i = 0; i < 4; i++) acc ^= v[8*i +: 8];
    return acc;
  endfunction

  task automatic put_char(input logic [7:0] ch, input logic [2:0] st);
    item_results.push_back('{1'b1, ch, st, 1'b0});
  endtask

  task automatic put_status(input logic [2:0] st);
    item_results.push_back('{1'b0, 8'h00, st, 1'b0});
  endtask

  // most significant digit first, lowercase
  task automatic put_hex(input logic [31:0] value, input int digits, input logic [2:0] st);
    logic [3:0] nib;
    int i;
    for (i = digits - 1; i >= 0; i--) begin
      nib = value[4*i +: 4];
      put_char((nib < 4'd10) ? 8'h30 + {4'h0, nib} : 8'h57 + {4'h0, nib}, st);
    end
  endtask

  // whole write record: W, address, length, data, checksum
  task automatic put_record(input logic [2:0] st);
    int i;
    put_char(CHAR_W, st);
    put_hex(rec_address, 8, st);
    put_hex({27'd0, rec_count}, 4, st);
    for (i = 0; i < rec_count; i++) put_hex({24'd0, rec_bytes[i]}, 2, st);
    put_hex({24'd0, rec_csum}, 2, st);
    rec_tries = rec_tries + 4'd1;
    link_phase = LINK_WAIT_WRITE;
  endtask

  // advance the model by one item, leaving its results in item_results
  task automatic advance_sender(input loader_item_t it);
    item_results.delete();
    if (it.op == OP_BEGIN && link_phase == LINK_IDLE) begin
      rec_address = it.address;
      rec_count = (it.record_length > 5'(RECORD_MAX)) ? 5'(RECORD_MAX) : it.record_length;
      rec_got = 5'd0;
      rec_csum = fold_bytes(it.address);
      rec_tries = 4'd0;
      if (rec_count == 5'd0) put_record(ST_NONE);
      else link_phase = LINK_COLLECT;
    end else if (it.op == OP_DATA && link_phase == LINK_COLLECT) begin
      if (rec_got < 5'(RECORD_MAX)) rec_bytes[rec_got[3:0]] = it.data_byte;
      rec_csum ^= it.data_byte;
      rec_got = rec_got + 5'd1;
      if (rec_got >= rec_count) put_record(ST_NONE);
    end else if (it.op == OP_JUMP && link_phase == LINK_IDLE) begin
      put_char(CHAR_J, ST_NONE);
      put_hex(it.address, 8, ST_NONE);
      put_hex(it.stack_value, 8, ST_NONE);
      put_hex({24'd0, fold_bytes(it.address) ^ fold_bytes(it.stack_value)}, 2, ST_NONE);
      link_phase = LINK_WAIT_JUMP;
    end else if (it.op == OP_REPLY && link_phase == LINK_WAIT_WRITE) begin
      // a limit of zero behaves as one: rec_tries is already one here
      if (it.reply_byte == CHAR_O) begin
        put_status(ST_OK);
        link_phase = LINK_IDLE;
      end else if (rec_tries < tries_limit) begin
        put_record(ST_RETRY);
      end else begin
        put_status(ST_FAIL);
        link_phase = LINK_IDLE;
      end
    end else if (it.op == OP_REPLY && link_phase == LINK_WAIT_JUMP) begin
      put_status((it.reply_byte == CHAR_O) ? ST_OK : ST_FAIL);
      link_phase = LINK_IDLE;
    end else begin
      // wrong phase: report only, state untouched
      put_status(ST_UNEXP);
    end
    if (item_results.size() > 0) item_results[$].last = 1'b1;
  endtask

  // ------------------------------------------------------------- stimulus

  function automatic loader_item_t random_item(input logic [1:0] op);
    loader_item_t it;
    it.op = op;
    it.address = $urandom;
    it.record_length = 5'($urandom_range(0, 31));
    it.data_byte = 8'($urandom_range(0, 255));
    it.stack_value = $urandom;
    it.reply_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // any reply byte except the ack
  function automatic logic [7:0] refusal_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CHAR_O) b = ~b;
    return b;
  endfunction

  // drive one item from a falling edge, hold it until taken, then predict;
  // returns at a falling edge with in_valid still high
  task automatic offer_item(input loader_item_t it, input bit typed,
                            input logic [2:0] typed_status);
    int unsigned gap;
    int i;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op = it.op;
    in_address = it.address;
    in_record_length = it.record_length;
    in_data_byte = it.data_byte;
    in_stack_value = it.stack_value;
    in_reply_byte = it.reply_byte;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    items_taken++;
    advance_sender(it);
    if (typed) begin
      link_results_due.push_back('{1'b0, 8'h00, typed_status, 1'b1});
    end else begin
      for (i = 0; i < item_results.size(); i++) link_results_due.push_back(item_results[i]);
    end
    @(negedge clk);
  endtask

  // register write once the output side has gone quiet
  task automatic set_max_tries(input logic [3:0] value);
    in_valid = 1'b0;
    while (link_results_due.size() != 0) @(negedge clk);
    // a begin or a partial data byte leaves nothing to wait for
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_max_tries = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tries_limit = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one random exchange: record with replies, jump with reply, or noise
  task automatic run_exchange();
    loader_item_t it;
    int unsigned pick;
    int unsigned bad_left;
    bit give_up;
    bit broken;
    bit stop_early;
    sender_steady = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it = random_item(OP_BEGIN);
      pick = $urandom_range(0, 99);
      // mostly short records, some full, a few oversize
      if (pick < 10) it.record_length = 5'd0;
      else if (pick < 78) it.record_length = 5'($urandom_range(1, 6));
      else if (pick < 90) it.record_length = 5'(RECORD_MAX);
      else it.record_length = 5'($urandom_range(RECORD_MAX + 1, 31));
      offer_item(it, 1'b0, ST_NONE);
      broken = ($urandom_range(0, 19) == 0);
      stop_early = 1'b0;
      while (link_phase == LINK_COLLECT && !stop_early) begin
        if ($urandom_range(0, 29) == 0) begin
          offer_item(random_item(2'($urandom_range(0, 3))), 1'b0, ST_NONE);
        end else if (broken && $urandom_range(0, 3) == 0) begin
          // abandon the record mid-way; later exchanges run into it
          stop_early = 1'b1;
        end else begin
          offer_item(random_item(OP_DATA), 1'b0, ST_NONE);
        end
      end
      give_up = ($urandom_range(0, 3) == 0);
      bad_left = $urandom_range(0, 3);
      while (link_phase == LINK_WAIT_WRITE) begin
        it = random_item(OP_REPLY);
        if ($urandom_range(0, 29) == 0) begin
          it.op = 2'($urandom_range(0, 2));
        end else if (give_up || bad_left > 0) begin
          it.reply_byte = refusal_byte();
          if (bad_left > 0) bad_left--;
        end else begin
          it.reply_byte = CHAR_O;
        end
        offer_item(it, 1'b0, ST_NONE);
      end
    end else if (pick < 85) begin
      offer_item(random_item(OP_JUMP), 1'b0, ST_NONE);
      if (link_phase == LINK_WAIT_JUMP) begin
        it = random_item(OP_REPLY);
        it.reply_byte = ($urandom_range(0, 3) == 0) ? refusal_byte() : CHAR_O;
        offer_item(it, 1'b0, ST_NONE);
      end
    end else begin
      repeat ($urandom_range(1, 3)) offer_item(random_item(2'($urandom_range(0, 3))),
                                                1'b0, ST_NONE);
    end
  endtask

  // main sequence
  initial begin
    loader_item_t it;
    logic [7:0] bump;
    logic [3:0] limits [5];
    int unsigned r;
    int unsigned k;
    int unsigned phase_end;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_BEGIN;
    in_address = 32'd0;
    in_record_length = 5'd0;
    in_data_byte = 8'd0;
    in_stack_value = 32'd0;
    in_reply_byte = 8'd0;
    cfg_valid = 1'b0;
    cfg_max_tries = 4'd0;
    sender_steady = 1'b0;
    items_taken = 0;
    mismatches = 0;
    link_phase = LINK_IDLE;
    rec_address = 32'd0;
    rec_count = 5'd0;
    rec_got = 5'd0;
    rec_csum = 8'd0;
    rec_tries = 4'd0;
    tries_limit = MAX_TRIES_RST;
    for (k = 0; k < RECORD_MAX; k++) rec_bytes[k] = 8'h00;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // opening table at the reset retry limit
    for (r = 0; r < OPENING_ROWS; r++) begin
      bump = 8'h00;
      for (k = 0; k < OPENING[r].copies; k++) begin
        it.op = OPENING[r].op;
        it.address = OPENING[r].address;
        it.record_length = OPENING[r].record_length;
        it.data_byte = OPENING[r].data_byte + bump;
        it.stack_value = OPENING[r].stack_value;
        it.reply_byte = OPENING[r].reply_byte;
        offer_item(it, OPENING[r].typed, OPENING[r].typed_status);
        bump = bump + 8'h11;
      end
    end

    // random exchanges under a limit of one, the highest, zero, a middle and the reset limit
    limits = '{4'd1, 4'd15, 4'd0, 4'($urandom_range(2, 14)), MAX_TRIES_RST};
    for (r = 0; r < 5; r++) begin
      set_max_tries(limits[r]);
      phase_end = items_taken + PHASE_ITEMS;
      while (items_taken < phase_end) run_exchange();
    end

    // drain, then watch for stray results
    in_valid = 1'b0;
    k = 0;
    while (link_results_due.size() != 0 && k < DRAIN_LIMIT) begin
      @(negedge clk);
      k++;
    end
    if (link_results_due.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", link_results_due.size()));
    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // ------------------------------------------------------------- receiver

  // random stalls with quiet stretches, plus one long hold-off that lets the
  // block back up and stall its input while items keep coming
  initial begin
    int unsigned stall_left;
    int unsigned free_left;
    bit pressure_done;
    out_stall = 1'b0;
    stall_left = 0;
    free_left = 0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && results_checked >= PRESSURE_AFTER) begin
        stall_left = PRESSURE_CYCLES;
        free_left = 0;
        pressure_done = 1'b1;
      end
      if (stall_left == 0 && free_left == 0) begin
        stall_left = pick_gap();
        free_left = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        free_left--;
      end
    end
  end

  // in-order check of every accepted result
  always @(posedge clk) begin
    link_result_t seen;
    link_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_has_char, out_link_char, out_status, out_last};
      if (link_results_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result: has_char %0b char %h status %0d last %0b",
                                seen.has_char, seen.link_char, seen.status, seen.last));
      end else begin
        want = link_results_due.pop_front();
        results_checked++;
        if (seen !== want)
          note_mismatch($sformatf(
            "result %0d: got has_char %0b char %h status %0d last %0b, want %0b %h %0d %0b",
            results_checked, seen.has_char, seen.link_char, seen.status, seen.last,
            want.has_char, want.link_char, want.status, want.last));
      end
    end
  end

  initial results_checked = 0;

endmodule
